// File: design/ntw_pkg.sv
package ntw_pkg;

   localparam int NUMBER_W = 31;
   localparam int WORD_W   = 5;
   localparam int BIN_W    = 32;              // number padded to an even bit count
   localparam int DIGITS   = 10;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int CONV_STEPS = BIN_W / 2;     // two bits per cycle
   localparam int CNT_W    = $clog2(CONV_STEPS);
   localparam int GROUPS   = 4;
   localparam int PHASES   = 5;
   localparam int MASK_W   = GROUPS * PHASES;

   localparam logic [WORD_W-1:0] W_ZERO     = 5'd0;
   localparam logic [WORD_W-1:0] W_TEN      = 5'd10;
   localparam logic [WORD_W-1:0] W_TENS_OFS = 5'd18;
   localparam logic [WORD_W-1:0] W_HUNDRED  = 5'd28;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MASK,
      ST_EMIT
   } state_type;

   // token slot within one base-1000 group
   typedef enum logic [2:0] {
      PH_HUND,
      PH_HUNDRED,
      PH_TENS,
      PH_UNIT,
      PH_SCALE
   } phase_type;

   typedef struct packed {
      logic load;
      logic step;
      logic build;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic last;
   } status_type;

   // one double-dabble iteration
   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                               input logic in_bit);
      logic [BCD_W-1:0] adj;
      adj = bcd;
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return {adj[BCD_W-2:0], in_bit};
   endfunction

   function automatic logic [WORD_W-1:0] token_word(input logic [11:0] grp,
                                                    input phase_type ph,
                                                    input logic [1:0] scale);
      logic [3:0] h;
      logic [3:0] t;
      logic [3:0] u;
      logic [WORD_W-1:0] w;
      h = grp[11:8];
      t = grp[7:4];
      u = grp[3:0];
      unique case (ph)
         PH_HUND:    w = {1'b0, h};
         PH_HUNDRED: w = W_HUNDRED;
         PH_TENS: begin
            if (t == 4'd0) begin
               w = {1'b0, u};
            end else if (t == 4'd1) begin
               w = W_TEN + {1'b0, u};
            end else begin
               w = W_TENS_OFS + {1'b0, t};
            end
         end
         PH_UNIT:    w = {1'b0, u};
         PH_SCALE:   w = W_HUNDRED + {3'b000, scale};
         default:    w = W_ZERO;
      endcase
      return w;
   endfunction

endpackage

// File: design/ntw_ctrl.sv
module ntw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ntw_pkg::status_type   status,
   output ntw_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import ntw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (status.conv_done) state_in = ST_MASK;
         end
         ST_MASK:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CONVERT: cmd.step = 1'b1;
         ST_MASK:    cmd.build = 1'b1;
         ST_EMIT: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
         end
         default:    busy = 1'b0;
      endcase
   end

endmodule

// File: design/ntw_datapath.sv
module ntw_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ntw_pkg::cmd_type               cmd,
   input  logic [ntw_pkg::NUMBER_W-1:0]   req_number,
   output ntw_pkg::status_type            status,
   output logic [ntw_pkg::WORD_W-1:0]     rsp_word,
   output logic                           rsp_last_word
);
   import ntw_pkg::*;

   logic [BIN_W-1:0]  bin_ff;
   logic [BCD_W-1:0]  bcd_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [MASK_W-1:0] mask_in;
   logic [MASK_W-1:0] mask_rest;
   logic [11:0]       grp [GROUPS];
   logic [1:0]        sel_grp;
   phase_type         sel_ph;

   // groups ordered most significant first; the billions group has one digit
   always_comb begin
      grp[0] = {8'h00, bcd_ff[39:36]};
      grp[1] = bcd_ff[35:24];
      grp[2] = bcd_ff[23:12];
      grp[3] = bcd_ff[11:0];
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         mask_in[g*PHASES + int'(PH_HUND)]    = grp[g][11:8] != 4'd0;
         mask_in[g*PHASES + int'(PH_HUNDRED)] = grp[g][11:8] != 4'd0;
         mask_in[g*PHASES + int'(PH_TENS)]    = grp[g][7:0] != 8'd0;
         mask_in[g*PHASES + int'(PH_UNIT)]    = grp[g][7:4] >= 4'd2 && grp[g][3:0] != 4'd0;
         mask_in[g*PHASES + int'(PH_SCALE)]   = g != GROUPS - 1 && grp[g] != 12'd0;
      end
   end

   // pick the first pending token slot
   always_comb begin
      logic found;
      found   = 1'b0;
      sel_grp = '0;
      sel_ph  = PH_HUND;
      for (int g = 0; g < GROUPS; g++) begin
         for (int p = 0; p < PHASES; p++) begin
            if (mask_ff[g*PHASES + p] && !found) begin
               found   = 1'b1;
               sel_grp = 2'(g);
               sel_ph  = phase_type'(3'(p));
            end
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - 1'b1);

   // empty mask means the number was zero
   assign rsp_word = (mask_ff == '0) ? W_ZERO
                   : token_word(grp[sel_grp], sel_ph, 2'd3 - sel_grp);
   assign rsp_last_word = mask_rest == '0;

   assign status.conv_done = cnt_ff == CNT_W'(CONV_STEPS - 1);
   assign status.last      = rsp_last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff <= {{(BIN_W-NUMBER_W){1'b0}}, req_number};
         bcd_ff <= '0;
      end else if (cmd.step) begin
         bin_ff <= {bin_ff[BIN_W-3:0], 2'b00};
         bcd_ff <= dabble(dabble(bcd_ff, bin_ff[BIN_W-1]), bin_ff[BIN_W-2]);
      end
      if (cmd.build) begin
         mask_ff <= mask_in;
      end else if (cmd.emit) begin
         mask_ff <= mask_rest;
      end
   end

endmodule

// File: design/number_to_word_tokens_unit.sv
// Channel  | Ports                                  | Transfer
// ---------+----------------------------------------+-----------------------------
// request  | start, busy, req_number[30:0]          | start high while busy low
// response | rsp_valid, rsp_word[4:0], rsp_last_word| one cycle per word, no stall
//
// One number gives N = 1..16 word tokens: the load in idle, binary to BCD
// conversion (two bits per cycle through the double-dabble register), the
// token mask build, then one token per cycle.
// busy stays high from the accepted transaction until the last token's cycle.
// Reset is synchronous and returns the controller to idle; nothing else to clear.
// The receiver cannot stall; tokens go out on consecutive cycles.
module number_to_word_tokens_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ntw_pkg::NUMBER_W-1:0]   req_number,
   output logic                           rsp_valid,
   output logic [ntw_pkg::WORD_W-1:0]     rsp_word,
   output logic                           rsp_last_word
);
   import ntw_pkg::*;

   cmd_type    cmd;
   status_type status;

   ntw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ntw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_number    (req_number),
      .status        (status),
      .rsp_word      (rsp_word),
      .rsp_last_word (rsp_last_word)
   );

endmodule

// File: design/ntw_checker.sv
module ntw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [ntw_pkg::WORD_W-1:0]     rsp_word,
   input logic                           rsp_last_word
);

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("word strobe outside a transaction");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transaction did not enter conversion");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |=> !busy && !rsp_valid)
      else $error("tokens continued after the last word");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> rsp_valid)
      else $error("gap in token stream");

   a_word_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_word, rsp_last_word}))
      else $error("unknown bits on a strobed word");

endmodule

bind number_to_word_tokens_unit ntw_checker u_ntw_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_word      (rsp_word),
   .rsp_last_word (rsp_last_word)
);

// File: test/number_to_word_tokens_unit_tb.sv
`timescale 1ns / 100ps

module number_to_word_tokens_unit_tb;

   localparam int NUM_W  = ntw_pkg::NUMBER_W;
   localparam int WORD_W = ntw_pkg::WORD_W;

   localparam logic [WORD_W-1:0] W_ZERO     = ntw_pkg::W_ZERO;
   localparam logic [WORD_W-1:0] W_TENS_OFS = ntw_pkg::W_TENS_OFS;
   localparam logic [WORD_W-1:0] W_HUNDRED  = ntw_pkg::W_HUNDRED;
   localparam logic [WORD_W-1:0] W_THOUSAND = ntw_pkg::W_HUNDRED + 5'd1;
   localparam logic [WORD_W-1:0] W_MILLION  = ntw_pkg::W_HUNDRED + 5'd2;
   localparam logic [WORD_W-1:0] W_BILLION  = ntw_pkg::W_HUNDRED + 5'd3;

   localparam longint NUM_MAX      = 64'd2147483647;
   localparam int     RANDOM_ITEMS = 356;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              last;
   } token_type;

   class word_scoreboard;
      token_type         expected_q[$];
      logic [WORD_W-1:0] spelled_words[$];
      int unsigned       fail_count;
      int unsigned       tokens_checked;
      int unsigned       numbers_noted;

      function new();
         fail_count     = 0;
         tokens_checked = 0;
         numbers_noted  = 0;
      endfunction

      // words of one base-1000 group, followed by its scale word if any
      function void add_group(int unsigned grp, logic [WORD_W-1:0] scale_word,
                              bit has_scale);
         int unsigned hund;
         int unsigned rest;
         hund = grp / 100;
         rest = grp % 100;
         if (grp == 0) begin
            return;
         end
         if (hund != 0) begin
            spelled_words.push_back(WORD_W'(hund));
            spelled_words.push_back(W_HUNDRED);
         end
         if (rest != 0) begin
            if (rest < 20) begin
               spelled_words.push_back(WORD_W'(rest));
            end else begin
               spelled_words.push_back(W_TENS_OFS + WORD_W'(rest / 10));
               if (rest % 10 != 0) begin
                  spelled_words.push_back(WORD_W'(rest % 10));
               end
            end
         end
         if (has_scale) begin
            spelled_words.push_back(scale_word);
         end
      endfunction

      function void note_number(logic [NUM_W-1:0] num);
         int unsigned v;
         token_type   tok;
         v = num;
         spelled_words.delete();
         if (v == 0) begin
            spelled_words.push_back(W_ZERO);
         end else begin
            add_group(v / 1000000000, W_BILLION, 1'b1);
            add_group((v / 1000000) % 1000, W_MILLION, 1'b1);
            add_group((v / 1000) % 1000, W_THOUSAND, 1'b1);
            add_group(v % 1000, W_ZERO, 1'b0);
         end
         foreach (spelled_words[i]) begin
            tok.word = spelled_words[i];
            tok.last = (i == spelled_words.size() - 1);
            expected_q.push_back(tok);
         end
         numbers_noted++;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         fail_count++;
      endtask

      task check_token(logic [WORD_W-1:0] word, logic last);
         token_type exp_tok;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected token word=%0d last_word=%0b", word, last));
            return;
         end
         exp_tok = expected_q.pop_front();
         tokens_checked++;
         if (word !== exp_tok.word) begin
            report($sformatf("word %0d, expected %0d", word, exp_tok.word));
         end
         if (last !== exp_tok.last) begin
            report($sformatf("last_word %0b, expected %0b (word %0d)",
                             last, exp_tok.last, exp_tok.word));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [NUM_W-1:0]  req_number;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_word;
   logic              rsp_last_word;

   word_scoreboard sb;

   number_to_word_tokens_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_number    (req_number),
      .rsp_valid     (rsp_valid),
      .rsp_word      (rsp_word),
      .rsp_last_word (rsp_last_word)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_token(rsp_word, rsp_last_word);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task send_number(logic [NUM_W-1:0] num);
      start      <= 1'b1;
      req_number <= num;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sb.note_number(num);
      @(negedge clock);
   endtask

   task hold_off(int unsigned cycles, bit drain);
      start      <= 1'b0;
      req_number <= NUM_W'($urandom());
      if (drain) begin
         while (sb.expected_q.size() != 0) begin
            @(negedge clock);
         end
      end
      repeat (cycles) @(negedge clock);
   endtask

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic int unsigned random_group();
      case ($urandom_range(0, 6))
         0: return 0;
         1: return $urandom_range(1, 19);
         2: return 10 * $urandom_range(2, 9);
         3: return 100 * $urandom_range(1, 9);
         4: return 100 * $urandom_range(1, 9) + $urandom_range(10, 19);
         default: return $urandom_range(0, 999);
      endcase
   endfunction

   function automatic logic [NUM_W-1:0] random_number();
      longint      val;
      int unsigned k;
      case ($urandom_range(0, 9))
         0, 1: val = longint'($urandom()) & NUM_MAX;
         2: val = $urandom_range(0, 999);
         3: val = $urandom_range(0, 20);
         4: begin
            k   = $urandom_range(0, 30);
            val = (longint'(1) << k) - longint'($urandom_range(0, 1));
         end
         default: begin
            val = longint'($urandom_range(0, 2)) * 1000000000
                + longint'(random_group()) * 1000000
                + longint'(random_group()) * 1000
                + longint'(random_group());
            // top group of 2 can overflow 31 bits; drop it to 1
            if (val > NUM_MAX) begin
               val = val - 1000000000;
            end
         end
      endcase
      return NUM_W'(val);
   endfunction

   logic [NUM_W-1:0] directed_q[$];
   int unsigned      gap;

   initial begin
      sb         = new();
      reset      = 1'b1;
      start      = 1'b0;
      req_number = '0;
      directed_q = '{0, 1, 9, 10, 11, 19, 20, 21, 99, 100, 101, 110, 119, 999,
                     1000, 1001, 1000000, 1000000000, 2000000000, 1000001,
                     1010010010, 1777777777, 1999999999, 2147483647,
                     31'h2AAAAAAA};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_q[i]) begin
         send_number(directed_q[i]);
         gap = gap_len();
         if (gap != 0) begin
            hold_off(gap, 1'b0);
         end
      end
      hold_off(0, 1'b1);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_number(random_number());
         if (i % 90 == 45) begin
            hold_off($urandom_range(0, 5), 1'b1);
         end else if (i < 150 || i >= 210) begin
            // items 150..209 go back to back
            gap = gap_len();
            if (gap != 0) begin
               hold_off(gap, 1'b0);
            end
         end
      end

      hold_off(0, 1'b1);
      repeat (40) @(negedge clock);
      if (sb.expected_q.size() != 0) begin
         sb.report($sformatf("%0d tokens never arrived", sb.expected_q.size()));
      end

      $display("Spelled %0d numbers (directed edge values and random group mixes)",
               sb.numbers_noted);
      $display("Checked %0d word tokens, %0d mismatches", sb.tokens_checked,
               sb.fail_count);
      if (sb.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d tokens outstanding", sb.expected_q.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: number_to_word_tokens_unit.f
design/ntw_pkg.sv
design/ntw_ctrl.sv
design/ntw_datapath.sv
design/number_to_word_tokens_unit.sv
design/ntw_checker.sv
test/number_to_word_tokens_unit_tb.sv
